@@ rtl/core/rle_run_literal_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// rle assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef RLE_RUN_LITERAL_DECODER_ASSERT_SVH
`define RLE_RUN_LITERAL_DECODER_ASSERT_SVH

// condition holds at every edge out of reset
`define RLE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RLE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/rle_pkg.sv @@
// ----------------------------------------------------------------------------
// rle package
// widths, sizes and the command beat passed from front to back
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int OUT_BYTES   = 8;
  localparam int BYTE_W      = 8;
  localparam int DATA_W      = OUT_BYTES * BYTE_W;
  localparam int COUNT_W     = 4;
  localparam int RUN_W       = 8;
  localparam int LEN_W       = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [RUN_W-1:0]  run_len;
    logic              done;
    logic              clip;
  } cmd_t;

endpackage

@@ rtl/core/rle_front.sv @@
// ----------------------------------------------------------------------------
// rle front
// parses packed bytes, tracks the block count and issues one command per
// literal byte or repeat
// ----------------------------------------------------------------------------
module rle_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rle_pkg::LEN_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rle_pkg::BYTE_W-1:0]      packed_byte,
  input  logic                            q_full,
  output logic                            q_push,
  output rle_pkg::cmd_t                   q_cmd
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  phase_t                        phase, phase_next;
  logic [rle_pkg::RUN_W-1:0]     literal_remaining, literal_remaining_next;
  logic [rle_pkg::RUN_W-1:0]     repeat_length, repeat_length_next;
  logic [rle_pkg::LEN_W-1:0]     decoded_count, decoded_count_next;
  logic [rle_pkg::LEN_W-1:0]     decoded_length;

  logic                          accept;
  logic [rle_pkg::LEN_W:0]       limit, avail;
  logic [rle_pkg::RUN_W-1:0]     lit_dec, rep_total, total_cut;
  logic                          lit_done, rep_clip, rep_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign limit = (decoded_length == '0) ? {1'b1, {rle_pkg::LEN_W{1'b0}}}
                                        : {1'b0, decoded_length};
  assign avail = (limit > {1'b0, decoded_count}) ? (limit - {1'b0, decoded_count})
                                                 : (rle_pkg::LEN_W+1)'(1);

  assign lit_dec   = literal_remaining - rle_pkg::RUN_W'(1);
  assign lit_done  = (avail == (rle_pkg::LEN_W+1)'(1));
  assign rep_total = (repeat_length == '0) ? rle_pkg::RUN_W'(1) : repeat_length;
  assign rep_clip  = ((rle_pkg::LEN_W+1)'(rep_total) > avail);
  assign total_cut = rep_clip ? avail[rle_pkg::RUN_W-1:0] : rep_total;
  assign rep_done  = ((rle_pkg::LEN_W+1)'(total_cut) == avail);

  always_comb begin
    phase_next             = phase;
    literal_remaining_next = literal_remaining;
    repeat_length_next     = repeat_length;
    decoded_count_next     = decoded_count;
    q_push                 = 1'b0;
    q_cmd.value            = packed_byte;
    q_cmd.run_len          = rle_pkg::RUN_W'(1);
    q_cmd.done             = 1'b0;
    q_cmd.clip             = 1'b0;
    if (accept) begin
      case (phase)
        PH_LITERAL: begin
          q_push                 = 1'b1;
          q_cmd.done             = lit_done;
          q_cmd.clip             = lit_done && (lit_dec != '0);
          literal_remaining_next = lit_dec;
          if (lit_done) begin
            decoded_count_next     = '0;
            phase_next             = PH_HEADER;
            literal_remaining_next = '0;
            repeat_length_next     = '0;
          end else begin
            decoded_count_next = decoded_count + rle_pkg::LEN_W'(1);
            if (lit_dec == '0) begin
              phase_next = PH_HEADER;
            end
          end
        end
        PH_REPEAT: begin
          q_push             = 1'b1;
          q_cmd.run_len      = total_cut;
          q_cmd.done         = rep_done;
          q_cmd.clip         = rep_clip;
          phase_next         = PH_HEADER;
          repeat_length_next = '0;
          if (rep_done) begin
            decoded_count_next     = '0;
            literal_remaining_next = '0;
          end else begin
            decoded_count_next = decoded_count + rle_pkg::LEN_W'(total_cut);
          end
        end
        default: begin
          if (packed_byte[rle_pkg::BYTE_W-1]) begin
            literal_remaining_next = {1'b0, packed_byte[rle_pkg::BYTE_W-2:0]}
                                     + rle_pkg::RUN_W'(1);
            phase_next             = PH_LITERAL;
          end else begin
            repeat_length_next = packed_byte + rle_pkg::RUN_W'(1);
            phase_next         = PH_REPEAT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      literal_remaining <= '0;
      repeat_length     <= '0;
      decoded_count     <= '0;
      decoded_length    <= rle_pkg::LEN_RESET;
    end else begin
      phase             <= phase_next;
      literal_remaining <= literal_remaining_next;
      repeat_length     <= repeat_length_next;
      decoded_count     <= decoded_count_next;
      if (cfg_write) begin
        decoded_length <= cfg_data;
      end
    end
  end

endmodule

@@ rtl/core/rle_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// rle command queue
// short register queue of command beats between front and back
// ----------------------------------------------------------------------------
`include "rle_run_literal_decoder_assert.svh"

module rle_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rle_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rle_pkg::cmd_t head_cmd
);

  rle_pkg::cmd_t                 entries [rle_pkg::QUEUE_DEPTH];
  logic [rle_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [rle_pkg::QCNT_W-1:0]    count;

  function automatic logic [rle_pkg::QPTR_W-1:0] ptr_inc(
    input logic [rle_pkg::QPTR_W-1:0] p
  );
    return (p == rle_pkg::QPTR_W'(rle_pkg::QUEUE_DEPTH - 1)) ? '0
                                                             : p + rle_pkg::QPTR_W'(1);
  endfunction

  assign full       = (count == rle_pkg::QCNT_W'(rle_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + rle_pkg::QCNT_W'(1);
        2'b01:   count <= count - rle_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `RLE_ASSERT_IMPLY(a_push_not_full, push, !full, "command pushed into full queue")
  `RLE_ASSERT_IMPLY(a_pop_not_empty, pop, head_valid, "command popped from empty queue")

endmodule

@@ rtl/core/rle_back.sv @@
// ----------------------------------------------------------------------------
// rle back
// expands each command into output words of up to OUT_BYTES bytes behind an
// output register
// ----------------------------------------------------------------------------
`include "rle_run_literal_decoder_assert.svh"

module rle_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  rle_pkg::cmd_t                   head_cmd,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rle_pkg::DATA_W-1:0]      data_word,
  output logic [rle_pkg::COUNT_W-1:0]     byte_count,
  output logic                            last_of_item,
  output logic                            block_done,
  output logic                            run_clipped
);

  logic                          busy;
  logic [rle_pkg::BYTE_W-1:0]    value;
  logic [rle_pkg::RUN_W-1:0]     remaining;
  logic                          done;
  logic                          clip;

  logic                          take, step, last;
  logic [rle_pkg::COUNT_W-1:0]   k;
  logic [rle_pkg::DATA_W-1:0]    word;

  assign take = !out_valid || !out_stall;
  assign step = busy && take;
  assign pop  = !busy && head_valid;
  assign last = (remaining <= rle_pkg::RUN_W'(rle_pkg::OUT_BYTES));
  assign k    = last ? rle_pkg::COUNT_W'(remaining)
                     : rle_pkg::COUNT_W'(rle_pkg::OUT_BYTES);

  always_comb begin
    for (int j = 0; j < rle_pkg::OUT_BYTES; j++) begin
      word[j*rle_pkg::BYTE_W +: rle_pkg::BYTE_W] =
        (rle_pkg::COUNT_W'(j) < k) ? value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value     <= head_cmd.value;
      remaining <= head_cmd.run_len;
      done      <= head_cmd.done;
      clip      <= head_cmd.clip;
    end else if (step) begin
      remaining <= remaining - rle_pkg::RUN_W'(k);
    end
    if (step) begin
      data_word    <= word;
      byte_count   <= k;
      last_of_item <= last;
      block_done   <= last && done;
      run_clipped  <= last && clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (step && last) begin
        busy <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RLE_ASSERT_IMPLY(a_count_range, out_valid,
                    (byte_count != '0) &&
                    (byte_count <= rle_pkg::COUNT_W'(rle_pkg::OUT_BYTES)),
                    "byte count out of range")
  `RLE_ASSERT_IMPLY(a_clip_on_last, out_valid && run_clipped, last_of_item,
                    "clip flag on a word that is not last")
  `RLE_ASSERT_IMPLY(a_done_on_last, out_valid && block_done, last_of_item,
                    "block end on a word that is not last")

endmodule

@@ rtl/core/rle_run_literal_decoder.sv @@
// ----------------------------------------------------------------------------
// rle run/literal decoder
// Packed-byte run-length decoder. The front takes one packed byte per cycle
// while the two-entry command queue has room: a header byte issues nothing,
// a literal byte issues one command, and the byte after a repeat header
// issues one command for the whole run. The back loads a command and then
// sends ceil(n / OUT_BYTES) beats for a run of n bytes, one per cycle while
// out_stall is low. in_stall rises while the command queue is full.
// decoded_length (0 meaning 65536, 1024 after reset) is written through
// cfg_write and cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. A run that passes the block
// end is cut and flagged on its last beat.
// ----------------------------------------------------------------------------
module rle_run_literal_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rle_pkg::LEN_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rle_pkg::BYTE_W-1:0]      packed_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rle_pkg::DATA_W-1:0]      data_word,
  output logic [rle_pkg::COUNT_W-1:0]     byte_count,
  output logic                            last_of_item,
  output logic                            block_done,
  output logic                            run_clipped
);

  logic          q_push, q_full, q_pop, q_valid;
  rle_pkg::cmd_t q_in, q_head;

  rle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .packed_byte (packed_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in)
  );

  rle_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  rle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_valid),
    .head_cmd     (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last_of_item (last_of_item),
    .block_done   (block_done),
    .run_clipped  (run_clipped)
  );

endmodule

@@ bench/tb_rle_run_literal_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle run/literal decoder testbench
// Drives packed bytes through the valid/stall input and checks every output
// beat against a cycle-free model of the decoder kept in the bench. Covers
// literal and repeat runs, block end with and without clipping, lengths
// written below the running count, random streams under several block
// lengths, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_rle_run_literal_decoder;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 24;

  typedef enum logic [2:0] {
    AWAIT_HEADER = 3'b001,
    IN_LITERAL   = 3'b010,
    IN_REPEAT    = 3'b100
  } parse_t;

  typedef struct {
    logic [rle_pkg::DATA_W-1:0]  word;
    logic [rle_pkg::COUNT_W-1:0] count;
    logic                        last;
    logic                        done;
    logic                        clip;
  } beat_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [rle_pkg::LEN_W-1:0]    cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [rle_pkg::BYTE_W-1:0]   packed_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [rle_pkg::DATA_W-1:0]   data_word;
  logic [rle_pkg::COUNT_W-1:0]  byte_count;
  logic                         last_of_item;
  logic                         block_done;
  logic                         run_clipped;

  // decoder model state
  parse_t                       phase_m = AWAIT_HEADER;
  logic [rle_pkg::RUN_W-1:0]    lit_left_m = '0;
  logic [rle_pkg::RUN_W-1:0]    rep_len_m = '0;
  logic [rle_pkg::LEN_W-1:0]    count_m = '0;
  logic [rle_pkg::LEN_W-1:0]    length_m = rle_pkg::LEN_RESET;

  beat_t               expected_words[$];

  bit                  tx_idle_on = 1'b1;
  bit                  rx_idle_on = 1'b1;
  int unsigned         hold_req_cnt = 0;
  int unsigned         hold_seen = 0;
  int                  rx_wait = 0;
  int                  quiet_cycles = 0;
  int                  errors = 0;
  int                  bytes_sent = 0;
  int                  words_checked = 0;
  int                  blocks_seen = 0;
  int                  clips_seen = 0;

  rle_run_literal_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .packed_byte  (packed_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last_of_item (last_of_item),
    .block_done   (block_done),
    .run_clipped  (run_clipped)
  );

  always #4 clk = ~clk;

  task automatic queue_beat(input logic [rle_pkg::DATA_W-1:0] w, input int n,
                            input logic l, input logic d, input logic c);
    beat_t bt;
    bt.word  = w;
    bt.count = rle_pkg::COUNT_W'(n);
    bt.last  = l;
    bt.done  = d;
    bt.clip  = c;
    expected_words.push_back(bt);
  endtask

  task automatic close_block();
    count_m    = '0;
    phase_m    = AWAIT_HEADER;
    lit_left_m = '0;
    rep_len_m  = '0;
  endtask

  // expected beats for one accepted packed byte
  task automatic decode_byte(input logic [rle_pkg::BYTE_W-1:0] b);
    int limit;
    int avail;
    int total;
    int pos;
    int k;
    logic clip;
    logic done;
    logic [rle_pkg::DATA_W-1:0] w;
    limit = (length_m == '0) ? 65536 : int'(length_m);
    avail = (limit > int'(count_m)) ? limit - int'(count_m) : 1;
    case (phase_m)
      IN_LITERAL: begin
        lit_left_m = lit_left_m - 1'b1;
        if (avail == 1) begin
          queue_beat(rle_pkg::DATA_W'(b), 1, 1'b1, 1'b1, lit_left_m != '0);
          close_block();
        end else begin
          queue_beat(rle_pkg::DATA_W'(b), 1, 1'b1, 1'b0, 1'b0);
          count_m = count_m + 1'b1;
          if (lit_left_m == '0) phase_m = AWAIT_HEADER;
        end
      end
      IN_REPEAT: begin
        total = (rep_len_m == '0) ? 1 : int'(rep_len_m);
        clip  = 1'b0;
        if (total > avail) begin
          total = avail;
          clip  = 1'b1;
        end
        done = (total == avail);
        pos  = 0;
        while (pos < total) begin
          k = (total - pos > rle_pkg::OUT_BYTES) ? rle_pkg::OUT_BYTES : total - pos;
          w = '0;
          for (int j = 0; j < k; j++) w |= rle_pkg::DATA_W'(b) << (rle_pkg::BYTE_W * j);
          pos += k;
          if (pos >= total) queue_beat(w, k, 1'b1, done, clip);
          else queue_beat(w, k, 1'b0, 1'b0, 1'b0);
        end
        if (done) begin
          close_block();
        end else begin
          count_m   = count_m + rle_pkg::LEN_W'(total);
          phase_m   = AWAIT_HEADER;
          rep_len_m = '0;
        end
      end
      default: begin
        if (b[7]) begin
          lit_left_m = {1'b0, b[6:0]} + 1'b1;
          phase_m    = IN_LITERAL;
        end else begin
          rep_len_m = b + 1'b1;
          phase_m   = IN_REPEAT;
        end
      end
    endcase
  endtask

  task automatic push_byte(input logic [rle_pkg::BYTE_W-1:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    packed_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [rle_pkg::LEN_W-1:0] v);
    settle();
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    length_m = v;
  endtask

  task automatic send_random_stream(input int n_items);
    int start;
    int pick;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
        push_byte(8'h80 | 8'(len - 1));
        repeat (len) push_byte(8'($urandom));
      end else if (pick < 90) begin
        len = $urandom_range(1, 128);
        push_byte(8'(len - 1));
        push_byte(8'($urandom));
      end else begin
        push_byte(8'($urandom));
      end
    end
  endtask

  task check_beat();
    beat_t exp_b;
    if (expected_words.size() == 0) begin
      $error("unexpected beat: data_word %h byte_count %0d", data_word, byte_count);
      errors++;
    end else begin
      exp_b = expected_words.pop_front();
      words_checked++;
      if (exp_b.done) blocks_seen++;
      if (exp_b.clip) clips_seen++;
      if (data_word !== exp_b.word) begin
        $error("data_word expected %h actual %h", exp_b.word, data_word);
        errors++;
      end
      if (byte_count !== exp_b.count) begin
        $error("byte_count expected %0d actual %0d", exp_b.count, byte_count);
        errors++;
      end
      if (last_of_item !== exp_b.last) begin
        $error("last_of_item expected %b actual %b", exp_b.last, last_of_item);
        errors++;
      end
      if (block_done !== exp_b.done) begin
        $error("block_done expected %b actual %b", exp_b.done, block_done);
        errors++;
      end
      if (run_clipped !== exp_b.clip) begin
        $error("run_clipped expected %b actual %b", exp_b.clip, run_clipped);
        errors++;
      end
    end
  endtask

  // output side: check, then draw the stall for the next beat
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_beat();
        rx_wait = rx_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        rx_wait   = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // reset length: single, full, exact-word and one-over runs, literals
  task automatic test_runs_and_literals();
    push_byte(8'h00); push_byte(8'hFF);
    push_byte(8'h7F); push_byte(8'hA5);
    push_byte(8'h07); push_byte(8'h3C);
    push_byte(8'h08); push_byte(8'h11);
    push_byte(8'h82); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h80);
  endtask

  // literal cut at the block end, exact repeat fill, clipped repeat, length of one
  task automatic test_block_end_clipping();
    set_length(16'd3);
    push_byte(8'h83); push_byte(8'h5A); push_byte(8'hA5); push_byte(8'h01);
    push_byte(8'h02); push_byte(8'h5A);
    push_byte(8'h05); push_byte(8'hC3);
    set_length(16'd1);
    push_byte(8'h80); push_byte(8'h99);
  endtask

  // new length written below the running count ends the block on the next byte that issues a command
  task automatic test_length_below_count();
    set_length(16'd100);
    push_byte(8'h1F); push_byte(8'h55);
    set_length(16'd20);
    push_byte(8'h80); push_byte(8'h66);
  endtask

  task automatic test_random_default_length();
    set_length(rle_pkg::LEN_RESET);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    send_random_stream(120);
  endtask

  task automatic test_random_short_blocks();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    repeat (3) begin
      set_length(rle_pkg::LEN_W'($urandom_range(2, 48)));
      send_random_stream(40);
    end
  endtask

  task automatic test_random_longest_block();
    set_length(16'hFFFF);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b0;
    send_random_stream(100);
  endtask

  task automatic test_random_tiny_blocks();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b1;
    repeat (2) begin
      set_length(rle_pkg::LEN_W'($urandom_range(1, 4)));
      send_random_stream(40);
    end
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_back_pressure();
    set_length(rle_pkg::LEN_RESET);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b1;
    hold_req_cnt <= hold_req_cnt + 1;
    push_byte(8'h9D);
    repeat (30) push_byte(8'($urandom));
    push_byte(8'h7F); push_byte(8'h33);
    push_byte(8'h40); push_byte(8'h01);
    tx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_runs_and_literals();
    test_block_end_clipping();
    test_length_below_count();
    test_random_default_length();
    test_random_short_blocks();
    test_random_longest_block();
    test_random_tiny_blocks();
    test_back_pressure();
    settle();
    if (expected_words.size() != 0) begin
      $error("%0d expected beats never arrived", expected_words.size());
      errors++;
    end
    $display("tb: %0d packed bytes sent, %0d output beats checked", bytes_sent, words_checked);
    $display("tb: %0d blocks ended, %0d clipped runs, block lengths 1 to 65535",
             blocks_seen, clips_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rle_pkg.sv
rtl/core/rle_front.sv
rtl/core/rle_cmd_fifo.sv
rtl/core/rle_back.sv
rtl/core/rle_run_literal_decoder.sv
bench/tb_rle_run_literal_decoder.sv
